FILE: src/fifo_multi_server_dispatcher_top_macros.svh
// assertion macros of the dispatcher, used by the queue module
`ifndef FIFO_MULTI_SERVER_DISPATCHER_TOP_MACROS_SVH
`define FIFO_MULTI_SERVER_DISPATCHER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define FMSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fmsd_pkg.sv
// types, constants and codes of the fifo multi-server dispatcher
`timescale 1ns / 1ps

package fmsd_pkg;

  localparam int NUM_SERVERS = 8;
  localparam int QUEUE_DEPTH = 64;

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SRV_IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SRV_CNT_W = $clog2(NUM_SERVERS + 1);

  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SERVERS_IN_USE = 1'b0;
  localparam logic [3:0] SERVERS_IN_USE_RESET = 4'd8;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_ASSIGN  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] job_id;
    logic [15:0] service_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_job_id;
    logic [3:0]  server_number;
    logic [31:0] wait_ticks;
    logic [3:0]  completed_count;
    logic [31:0] clock_value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] svc;
    logic [31:0] stamp;
  } job_t;

  // signals that ripple along the row of server cells
  typedef struct packed {
    logic                 offer;
    logic [SRV_IDX_W-1:0] pick;
    logic [SRV_CNT_W-1:0] done_cnt;
  } link_t;

endpackage

FILE: src/fmsd_cell.sv
// one server cell: remaining-time counter, claim of an offered job, completion count
`timescale 1ns / 1ps

module fmsd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fmsd_pkg::SRV_IDX_W-1:0] cell_num,
  input  logic                           in_use,
  input  logic                           tick,
  input  logic [15:0]                    svc,
  input  fmsd_pkg::link_t                link_in,
  output fmsd_pkg::link_t                link_out
);

  logic [15:0] remaining;
  logic        free;
  logic        take;
  logic        finishing;

  assign free      = (remaining == 16'd0);
  assign take      = link_in.offer && free && in_use;
  assign finishing = tick && (remaining == 16'd1);

  always_comb begin
    link_out          = link_in;
    // the first free cell in use claims the job and stops the offer
    if (take) begin
      link_out.offer = 1'b0;
      link_out.pick  = cell_num;
    end
    link_out.done_cnt = link_in.done_cnt + fmsd_pkg::SRV_CNT_W'(finishing);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 16'd0;
    end else if (take) begin
      remaining <= svc;
    end else if (tick && !free) begin
      remaining <= remaining - 16'd1;
    end
  end

endmodule

FILE: src/fmsd_queue.sv
// job queue: circular buffer in a memory with head, tail and fill count
`timescale 1ns / 1ps
`include "fifo_multi_server_dispatcher_top_macros.svh"

module fmsd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  fmsd_pkg::job_t              wr_data,
  input  logic                        pop,
  output fmsd_pkg::job_t              rd_data,
  output logic [fmsd_pkg::QCNT_W-1:0] count
);

  fmsd_pkg::job_t mem [fmsd_pkg::QUEUE_DEPTH];

  logic [fmsd_pkg::PTR_W-1:0] head;
  logic [fmsd_pkg::PTR_W-1:0] tail;

  function automatic logic [fmsd_pkg::PTR_W-1:0] ptr_inc(
    input logic [fmsd_pkg::PTR_W-1:0] p
  );
    if (p == fmsd_pkg::PTR_W'(fmsd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + fmsd_pkg::PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_data;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        count <= count + fmsd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - fmsd_pkg::QCNT_W'(1);
      end
    end
  end

  `FMSD_ASSERT_NOW(a_count_bound, 1'b1, count <= fmsd_pkg::QCNT_W'(fmsd_pkg::QUEUE_DEPTH), "queue count above depth")
  `FMSD_ASSERT_NOW(a_pop_nonempty, pop, count != '0, "pop from empty queue")
  `FMSD_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + fmsd_pkg::QCNT_W'(1), "push did not grow count")
  `FMSD_ASSERT_NOW(a_empty_ptrs, count == '0, head == tail, "empty queue with pointers apart")

endmodule

FILE: src/fifo_multi_server_dispatcher_top.sv
// top level of the fifo multi-server dispatcher: control, config port, cell row
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   start, busy, req                        word taken when start & !busy
//  result    result_valid, result                    each word valid a single cycle, no stall
//  config    psel penable pwrite paddr pwdata        written on psel&penable&pwrite
//            prdata pready                           pready tied high
//
// an arrival's word appears the next cycle and busy stays low
// a tick keeps busy high through its assignments: each dispatch step waits
// on the registered queue memory read, then one search finds no job or no
// free server, then one step for the countdown
// the servers ripple the first-free search and completion count along the cell row
// rst is synchronous: queue empty, servers free, clock 0, servers_in_use 8
`timescale 1ns / 1ps

module fifo_multi_server_dispatcher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fmsd_pkg::in_t                 req,
  output logic                          result_valid,
  output fmsd_pkg::out_t                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DISP  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_COUNT = 2'd3;

  logic [1:0]  state;
  logic [3:0]  servers_in_use;
  logic [31:0] tick_clock;

  logic                                reg_wr;
  logic [fmsd_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                                accept;
  logic                                full;
  logic                                push;
  logic                                pop;
  logic                                taken;
  logic [15:0]                         svc_fix;
  fmsd_pkg::job_t                      wr_job;
  fmsd_pkg::job_t                      head_job;
  logic [fmsd_pkg::QCNT_W-1:0]         qcount;
  logic [31:0]                         active;
  logic [31:0]                         num_full;
  logic [31:0]                         done_full;
  logic [3:0]                          done_sat;
  fmsd_pkg::link_t                     link [fmsd_pkg::NUM_SERVERS + 1];

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[fmsd_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      fmsd_pkg::REG_SERVERS_IN_USE: prdata = {28'd0, servers_in_use};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= fmsd_pkg::SERVERS_IN_USE_RESET;
    end else if (reg_wr && reg_idx == fmsd_pkg::REG_SERVERS_IN_USE) begin
      servers_in_use <= pwdata[3:0];
    end
  end

  // dispatch width clamped to 1..NUM_SERVERS
  always_comb begin
    if (servers_in_use == 4'd0) begin
      active = 32'd1;
    end else if (32'(servers_in_use) > 32'(fmsd_pkg::NUM_SERVERS)) begin
      active = 32'(fmsd_pkg::NUM_SERVERS);
    end else begin
      active = 32'(servers_in_use);
    end
  end

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (qcount == fmsd_pkg::QCNT_W'(fmsd_pkg::QUEUE_DEPTH));
  assign svc_fix = (req.service_time == 16'd0) ? 16'd1 : req.service_time;
  assign push    = accept && (req.req_type == fmsd_pkg::REQ_ARRIVAL) && !full;

  assign wr_job.id    = req.job_id;
  assign wr_job.svc   = svc_fix;
  assign wr_job.stamp = tick_clock;

  fmsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_job),
    .pop     (pop),
    .rd_data (head_job),
    .count   (qcount)
  );

  // row of server cells
  assign link[0].offer    = (state == ST_DISP) && (qcount != '0);
  assign link[0].pick     = '0;
  assign link[0].done_cnt = '0;

  for (genvar i = 0; i < fmsd_pkg::NUM_SERVERS; i++) begin : g_cell
    fmsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_num (fmsd_pkg::SRV_IDX_W'(i)),
      .in_use   (32'(i) < active),
      .tick     (state == ST_COUNT),
      .svc      (head_job.svc),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  assign taken     = link[0].offer && !link[fmsd_pkg::NUM_SERVERS].offer;
  assign pop       = taken;
  assign num_full  = 32'(link[fmsd_pkg::NUM_SERVERS].pick) + 32'd1;
  assign done_full = 32'(link[fmsd_pkg::NUM_SERVERS].done_cnt);
  assign done_sat  = (done_full > 32'd15) ? 4'd15 : done_full[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_clock   <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == fmsd_pkg::REQ_ARRIVAL) begin
              result_valid <= 1'b1;
            end else begin
              state <= ST_DISP;
            end
          end
        end
        ST_DISP: begin
          if (taken) begin
            result_valid <= 1'b1;
            state        <= ST_READ;
          end else begin
            state <= ST_COUNT;
          end
        end
        ST_READ: begin
          // wait for the new head entry out of the queue memory
          state <= ST_DISP;
        end
        ST_COUNT: begin
          result_valid <= 1'b1;
          tick_clock   <= tick_clock + 32'd1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      result.kind            <= full ? fmsd_pkg::KIND_DROP : fmsd_pkg::KIND_ACCEPT;
      result.out_job_id      <= req.job_id;
      result.server_number   <= 4'd0;
      result.wait_ticks      <= 32'd0;
      result.completed_count <= 4'd0;
      result.clock_value     <= tick_clock;
      result.last            <= 1'b1;
    end else if (state == ST_DISP) begin
      result.kind            <= fmsd_pkg::KIND_ASSIGN;
      result.out_job_id      <= head_job.id;
      result.server_number   <= num_full[3:0];
      result.wait_ticks      <= tick_clock - head_job.stamp;
      result.completed_count <= 4'd0;
      result.clock_value     <= tick_clock;
      result.last            <= 1'b0;
    end else if (state == ST_COUNT) begin
      result.kind            <= fmsd_pkg::KIND_SUMMARY;
      result.out_job_id      <= 16'd0;
      result.server_number   <= 4'd0;
      result.wait_ticks      <= 32'd0;
      result.completed_count <= done_sat;
      result.clock_value     <= tick_clock;
      result.last            <= 1'b1;
    end
  end

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the fifo multi-server dispatcher
`timescale 1ns / 1ps

module tb_top;
  import fmsd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [PADDR_W-1:0] ADDR_SERVERS  = {REG_SERVERS_IN_USE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_PAST_END = PADDR_W'(4 * (REG_SERVERS_IN_USE + 1));

  typedef struct {
    in_t  item;
    bit   has_word;
    out_t word;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  in_t                req;
  logic               result_valid;
  out_t               result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // dispatcher image kept by the testbench
  job_t        waiting_jobs[$];
  logic [15:0] server_left[NUM_SERVERS];
  logic [31:0] tick_count;
  logic [3:0]  srv_cfg;
  out_t        pending_words[$];

  bit   row_has_word;
  out_t row_word;
  int   mismatches;
  int   idle_cycles;
  int   burst_left;
  bit   progress;
  out_t want;

  fifo_multi_server_dispatcher_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  task automatic note_mismatch(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    $display("%0t: %s expected %0h, actual %0h", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  task automatic dispatch_predict(input in_t x, input bit typed, input out_t typed_word);
    job_t j;
    out_t w;
    int   active;
    int   pick;
    int   done;
    bit   found;
    if (x.req_type == REQ_ARRIVAL) begin
      w = '0;
      w.out_job_id = x.job_id;
      w.clock_value = tick_count;
      w.last = 1'b1;
      if (waiting_jobs.size() >= QUEUE_DEPTH) begin
        w.kind = KIND_DROP;
      end else begin
        w.kind = KIND_ACCEPT;
        j.id = x.job_id;
        j.svc = (x.service_time == 16'd0) ? 16'd1 : x.service_time;
        j.stamp = tick_count;
        waiting_jobs.push_back(j);
      end
      pending_words.push_back(typed ? typed_word : w);
    end else begin
      active = (srv_cfg == 4'd0) ? 1 : int'(srv_cfg);
      if (active > NUM_SERVERS) active = NUM_SERVERS;
      found = 1'b1;
      while (waiting_jobs.size() > 0 && found) begin
        found = 1'b0;
        pick = 0;
        for (int s = active - 1; s >= 0; s--) begin
          if (server_left[s] == 16'd0) begin
            found = 1'b1;
            pick = s;
          end
        end
        if (found) begin
          j = waiting_jobs.pop_front();
          server_left[pick] = j.svc;
          w = '0;
          w.kind = KIND_ASSIGN;
          w.out_job_id = j.id;
          w.server_number = 4'(pick + 1);
          w.wait_ticks = tick_count - j.stamp;
          w.clock_value = tick_count;
          pending_words.push_back(w);
        end
      end
      done = 0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        if (server_left[s] != 16'd0) begin
          server_left[s] = server_left[s] - 16'd1;
          if (server_left[s] == 16'd0) done++;
        end
      end
      w = '0;
      w.kind = KIND_SUMMARY;
      w.completed_count = (done > 15) ? 4'd15 : 4'(done);
      w.clock_value = tick_count;
      w.last = 1'b1;
      pending_words.push_back(typed ? typed_word : w);
      tick_count = tick_count + 32'd1;
    end
  endtask

  // prediction, checking and watchdog, all on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (start && !busy) begin
        dispatch_predict(req, row_has_word, row_word);
        progress = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_SERVERS_IN_USE) srv_cfg = pwdata[3:0];
        progress = 1'b1;
      end
      if (result_valid) begin
        progress = 1'b1;
        if (pending_words.size() == 0) begin
          note_mismatch("unexpected word", '0, 32'(result));
        end else begin
          want = pending_words.pop_front();
          if (result.kind !== want.kind)
            note_mismatch("kind", 32'(want.kind), 32'(result.kind));
          if (result.out_job_id !== want.out_job_id)
            note_mismatch("out_job_id", 32'(want.out_job_id), 32'(result.out_job_id));
          if (result.server_number !== want.server_number)
            note_mismatch("server_number", 32'(want.server_number),
                          32'(result.server_number));
          if (result.wait_ticks !== want.wait_ticks)
            note_mismatch("wait_ticks", want.wait_ticks, result.wait_ticks);
          if (result.completed_count !== want.completed_count)
            note_mismatch("completed_count", 32'(want.completed_count),
                          32'(result.completed_count));
          if (result.clock_value !== want.clock_value)
            note_mismatch("clock_value", want.clock_value, result.clock_value);
          if (result.last !== want.last)
            note_mismatch("last", 32'(want.last), 32'(result.last));
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic row_t mk_row(input bit is_tick, input logic [15:0] id,
                                  input logic [15:0] svc, input bit typed,
                                  input logic [1:0] kind, input logic [31:0] at_clock);
    row_t r;
    r.item.req_type = is_tick ? REQ_TICK : REQ_ARRIVAL;
    r.item.job_id = id;
    r.item.service_time = svc;
    r.has_word = typed;
    r.word = '0;
    r.word.kind = kind;
    r.word.out_job_id = is_tick ? 16'd0 : id;
    r.word.clock_value = at_clock;
    r.word.last = 1'b1;
    return r;
  endfunction

  // one word to the block, then maybe a gap once the burst runs out
  task automatic send_word(input in_t x, input bit typed, input out_t typed_word);
    int gap;
    in_t noise;
    @(negedge clk);
    start <= 1'b1;
    req <= x;
    row_has_word <= typed;
    row_word <= typed_word;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        noise.req_type = 1'($urandom_range(0, 1));
        noise.job_id = 16'($urandom);
        noise.service_time = 16'($urandom);
        @(negedge clk);
        start <= 1'b0;
        req <= noise;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic apb_xfer(input bit wr, input logic [PADDR_W-1:0] addr,
                          input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    wait (pending_words.size() == 0);
    repeat (6) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_servers(input logic [3:0] n);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, ADDR_SERVERS, {28'($urandom), n}, rd);
    apb_xfer(1'b0, ADDR_SERVERS, '0, rd);
    if (rd[3:0] !== n) note_mismatch("servers_in_use readback", 32'(n), 32'(rd[3:0]));
  endtask

  initial begin
    row_t        dir_rows[14];
    logic [3:0]  phase_cfg[6];
    int          phase_len[6];
    int          phase_tick_pct[6];
    logic [31:0] rd;
    in_t         x;
    out_t        no_word;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_has_word = 1'b0;
    row_word = '0;
    no_word = '0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 1;
    tick_count = '0;
    srv_cfg = SERVERS_IN_USE_RESET;
    foreach (server_left[s]) server_left[s] = '0;

    // tick on an empty queue, zero service time, id extremes, then eight jobs
    // in one tick so that the last one lands on the top server with the longest time
    dir_rows[0]  = mk_row(1'b1, 16'h0000, 16'h0000, 1'b1, KIND_SUMMARY, 32'd0);
    dir_rows[1]  = mk_row(1'b0, 16'h0000, 16'h0000, 1'b1, KIND_ACCEPT,  32'd1);
    dir_rows[2]  = mk_row(1'b0, 16'hffff, 16'h0001, 1'b1, KIND_ACCEPT,  32'd1);
    dir_rows[3]  = mk_row(1'b0, 16'h0001, 16'h0002, 1'b1, KIND_ACCEPT,  32'd1);
    dir_rows[4]  = mk_row(1'b0, 16'h8000, 16'h0003, 1'b0, KIND_ACCEPT,  32'd0);
    dir_rows[5]  = mk_row(1'b0, 16'h00ff, 16'h0001, 1'b0, KIND_ACCEPT,  32'd0);
    dir_rows[6]  = mk_row(1'b0, 16'h0f0f, 16'h0004, 1'b0, KIND_ACCEPT,  32'd0);
    dir_rows[7]  = mk_row(1'b0, 16'ha5a5, 16'h0002, 1'b0, KIND_ACCEPT,  32'd0);
    dir_rows[8]  = mk_row(1'b0, 16'h5a5a, 16'hffff, 1'b0, KIND_ACCEPT,  32'd0);
    dir_rows[9]  = mk_row(1'b1, 16'hffff, 16'hffff, 1'b0, KIND_SUMMARY, 32'd0);
    dir_rows[10] = mk_row(1'b0, 16'h1111, 16'h0005, 1'b1, KIND_ACCEPT,  32'd2);
    dir_rows[11] = mk_row(1'b1, 16'h0000, 16'h0000, 1'b0, KIND_SUMMARY, 32'd0);
    dir_rows[12] = mk_row(1'b1, 16'h7777, 16'h8888, 1'b0, KIND_SUMMARY, 32'd0);
    dir_rows[13] = mk_row(1'b1, 16'h0000, 16'h0000, 1'b0, KIND_SUMMARY, 32'd0);

    // first phase floods one server so the queue fills and drops
    phase_cfg      = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd0};
    phase_len      = '{80, 30, 25, 30, 25, 30};
    phase_tick_pct = '{8, 50, 40, 45, 40, 40};
    phase_cfg[5]   = 4'($urandom_range(1, NUM_SERVERS));

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);

    apb_xfer(1'b0, ADDR_SERVERS, '0, rd);
    if (rd[3:0] !== SERVERS_IN_USE_RESET)
      note_mismatch("servers_in_use after reset", 32'(SERVERS_IN_USE_RESET), 32'(rd[3:0]));

    foreach (dir_rows[i]) send_word(dir_rows[i].item, dir_rows[i].has_word, dir_rows[i].word);

    for (int p = 0; p < 6; p++) begin
      @(negedge clk);
      start <= 1'b0;
      set_servers(phase_cfg[p]);
      // a write past the last register must leave the dispatch unchanged
      if (p == 2) apb_xfer(1'b1, ADDR_PAST_END, $urandom, rd);
      for (int k = 0; k < phase_len[p]; k++) begin
        x.req_type = ($urandom_range(0, 99) < phase_tick_pct[p]) ? REQ_TICK : REQ_ARRIVAL;
        x.job_id = 16'($urandom);
        case ($urandom_range(0, 15))
          0:       x.service_time = 16'd0;
          1:       x.service_time = 16'($urandom_range(7, 40));
          default: x.service_time = 16'($urandom_range(1, 6));
        endcase
        send_word(x, 1'b0, no_word);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
